/* rtl/core/sdcd_pkg.sv */
// Shared types and constants for the serial dimmer command decoder.
// Used by sdcd_line_parser and serial_dimmer_command_decoder; no dependencies.
package sdcd_pkg;

  localparam logic [7:0] CHAR_NUL   = 8'd0;
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_VT    = 8'd11;
  localparam logic [7:0] CHAR_FF    = 8'd12;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_PLUS  = 8'd43;
  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;
  localparam logic [7:0] CHAR_F     = 8'd70;
  localparam logic [7:0] CHAR_N     = 8'd78;
  localparam logic [7:0] CHAR_O     = 8'd79;

  localparam logic [2:0] KW_START = 3'd0;
  localparam logic [2:0] KW_O     = 3'd1;
  localparam logic [2:0] KW_ON    = 3'd2;
  localparam logic [2:0] KW_OF    = 3'd3;
  localparam logic [2:0] KW_OFF   = 3'd4;
  localparam logic [2:0] KW_NONE  = 3'd5;

  localparam logic [1:0] PH_BLANK = 2'd0;
  localparam logic [1:0] PH_DIGIT = 2'd1;
  localparam logic [1:0] PH_STOP  = 2'd2;

  localparam logic [1:0] KIND_ON      = 2'd0;
  localparam logic [1:0] KIND_OFF     = 2'd1;
  localparam logic [1:0] KIND_SET     = 2'd2;
  localparam logic [1:0] KIND_INVALID = 2'd3;

  localparam logic [7:0] FULL_DUTY   = 8'd255;
  localparam logic [7:0] ZERO_DUTY   = 8'd0;
  localparam logic [6:0] MAX_PERCENT = 7'd100;
  localparam logic [6:0] MAG_SAT     = 7'd101;

  // Division by 100 is a multiply by round_up(2^22 / 100) and a shift by 22.
  localparam logic [15:0] DUTY_RECIP = 16'd41944;
  localparam int          DUTY_SHIFT = 22;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] percent;
    logic [7:0] duty;
  } reply_t;

endpackage

/* rtl/core/sdcd_line_parser.sv */
// Per-character line state and end-of-line classification for the decoder.
// Depends on sdcd_pkg for character codes, state codes and the reply type.
module sdcd_line_parser import sdcd_pkg::*; #(
  parameter int LINE_MAX = 19
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] rx_byte,
  output logic       done,
  output reply_t     reply
);

  localparam int CW = $clog2(LINE_MAX + 1);
  localparam logic [CW-1:0] LAST_COUNT = CW'(LINE_MAX - 1);

  logic [CW-1:0] char_count, char_count_next;
  logic          nul_seen, nul_seen_next;
  logic [2:0]    keyword_match, keyword_match_next;
  logic [1:0]    number_phase, number_phase_next;
  logic          negative_sign, negative_sign_next;
  logic [6:0]    magnitude, magnitude_next;
  logic [7:0]    current_duty, current_duty_next;

  logic [2:0]  kw;
  logic [1:0]  ph;
  logic        neg;
  logic [6:0]  mag;
  logic [9:0]  mag_acc;
  logic        eol;
  logic        is_blank;
  logic        is_digit;
  logic [14:0] scaled;
  logic [30:0] prod;
  logic [7:0]  set_duty;

  assign scaled   = (15'(mag) << 8) - 15'(mag);
  assign prod     = 31'(scaled) * 31'(DUTY_RECIP);
  assign set_duty = prod[DUTY_SHIFT+7:DUTY_SHIFT];

  always_comb begin
    eol      = (rx_byte == CHAR_CR) || (rx_byte == CHAR_LF);
    is_blank = (rx_byte == CHAR_SPACE) || (rx_byte == CHAR_TAB) ||
               (rx_byte == CHAR_VT) || (rx_byte == CHAR_FF);
    is_digit = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
    kw       = keyword_match;
    ph       = number_phase;
    neg      = negative_sign;
    mag      = magnitude;
    mag_acc  = '0;
    nul_seen_next   = nul_seen;
    char_count_next = char_count;
    done            = eol;

    if (!eol) begin
      if (!nul_seen) begin
        if (rx_byte == CHAR_NUL) begin
          nul_seen_next = 1'b1;
        end else begin
          case (keyword_match)
            KW_START: kw = (rx_byte == CHAR_O) ? KW_O : KW_NONE;
            KW_O: begin
              if (rx_byte == CHAR_N) begin
                kw = KW_ON;
              end else if (rx_byte == CHAR_F) begin
                kw = KW_OF;
              end else begin
                kw = KW_NONE;
              end
            end
            KW_OF:   kw = (rx_byte == CHAR_F) ? KW_OFF : KW_NONE;
            default: kw = KW_NONE;
          endcase

          if (number_phase == PH_BLANK) begin
            if (is_blank) begin
              ph = PH_BLANK;
            end else if ((rx_byte == CHAR_MINUS) || (rx_byte == CHAR_PLUS)) begin
              neg = (rx_byte == CHAR_MINUS);
              ph  = PH_STOP;
            end else begin
              ph = PH_DIGIT;
            end
          end
          if (ph == PH_DIGIT) begin
            if (is_digit) begin
              mag_acc = 10'(magnitude) * 10'd10 + 10'(rx_byte - CHAR_ZERO);
              mag     = (mag_acc > 10'(MAG_SAT)) ? MAG_SAT : mag_acc[6:0];
            end else begin
              ph = PH_STOP;
            end
          end
          // A sign moves straight to digit reading for the next character.
          if ((number_phase == PH_BLANK) &&
              ((rx_byte == CHAR_MINUS) || (rx_byte == CHAR_PLUS))) begin
            ph = PH_DIGIT;
          end
        end
      end
      char_count_next = char_count + CW'(1);
      done            = (char_count == LAST_COUNT);
    end

    reply.duty = current_duty;
    if (kw == KW_ON) begin
      reply.kind    = KIND_ON;
      reply.percent = MAX_PERCENT;
      reply.duty    = FULL_DUTY;
    end else if (kw == KW_OFF) begin
      reply.kind    = KIND_OFF;
      reply.percent = '0;
      reply.duty    = ZERO_DUTY;
    end else if ((mag <= MAX_PERCENT) && (!neg || (mag == '0))) begin
      reply.kind    = KIND_SET;
      reply.percent = mag;
      reply.duty    = set_duty;
    end else begin
      reply.kind    = KIND_INVALID;
      reply.percent = '0;
    end

    keyword_match_next = kw;
    number_phase_next  = ph;
    negative_sign_next = neg;
    magnitude_next     = mag;
    current_duty_next  = current_duty;
    if (done) begin
      char_count_next    = '0;
      nul_seen_next      = 1'b0;
      keyword_match_next = KW_START;
      number_phase_next  = PH_BLANK;
      negative_sign_next = 1'b0;
      magnitude_next     = '0;
      current_duty_next  = reply.duty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count    <= '0;
      nul_seen      <= 1'b0;
      keyword_match <= KW_START;
      number_phase  <= PH_BLANK;
      negative_sign <= 1'b0;
      magnitude     <= '0;
      current_duty  <= ZERO_DUTY;
    end else if (step) begin
      char_count    <= char_count_next;
      nul_seen      <= nul_seen_next;
      keyword_match <= keyword_match_next;
      number_phase  <= number_phase_next;
      negative_sign <= negative_sign_next;
      magnitude     <= magnitude_next;
      current_duty  <= current_duty_next;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    char_count < CW'(LINE_MAX))
    else $error("line length counter passed the line limit");

  a_mag_range: assert property (@(posedge clk) disable iff (rst)
    magnitude <= MAG_SAT)
    else $error("magnitude passed its saturation value");

  a_line_clear: assert property (@(posedge clk) disable iff (rst)
    (step && done) |=> (char_count == '0) && (magnitude == '0) && !nul_seen)
    else $error("line state not cleared after a finished line");

endmodule

/* rtl/core/serial_dimmer_command_decoder.sv */
// Top level of the serial dimmer command decoder: input register, line parser,
// result register. Depends on sdcd_pkg and sdcd_line_parser.
//
// Usage: received characters enter as words on the input channel (in_valid,
// in_ready, rx_byte). A line ends at CR or LF, or when the LINE_MAX-th
// character is stored. Each finished line gives one word on the output
// channel (out_valid, out_ready, reply_kind, percent, duty): ON gives duty
// 255, OFF gives duty 0, a leading number from 0 to 100 gives value*255/100
// (no number counts as 0); above 100 or below 0 is invalid, duty unchanged.
// Throughput is one input word per cycle while the result register is not held
// by a stall. A word waits in the input register while the parser updates the
// line state; the result of a line ending word and out_valid are written to the
// result register together when the parser steps on that word.
// The input register moves on whenever the result register is empty or being
// read, so a stall at the receiver holds one result, one pending input word,
// and then drops in_ready until out_ready returns. Reset clears the line
// state, the duty (to 0) and both valid flags; no output is produced for reset.
module serial_dimmer_command_decoder import sdcd_pkg::*; #(
  parameter int LINE_MAX = 19
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] reply_kind,
  output logic [6:0] percent,
  output logic [7:0] duty
);

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       advance;
  logic       line_done;
  reply_t     line_reply;
  reply_t     out_reply;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  sdcd_line_parser #(
    .LINE_MAX(LINE_MAX)
  ) u_parser (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .rx_byte(s1_byte),
    .done   (line_done),
    .reply  (line_reply)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && line_done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && line_done) begin
      out_reply <= line_reply;
    end
  end

  assign reply_kind = out_reply.kind;
  assign percent    = out_reply.percent;
  assign duty       = out_reply.duty;

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ready)
    else $error("input not ready while the input register is empty");

  a_on_reply: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (reply_kind == KIND_ON)) |-> (duty == FULL_DUTY) &&
    (percent == MAX_PERCENT))
    else $error("ON reply with wrong duty or percent");

  a_percent_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (percent <= MAX_PERCENT))
    else $error("reported percent above the maximum");

endmodule
